// File: rtl/core/bmf_pkg.sv
package bmf_pkg;

  localparam int PIX_W        = 8;
  localparam int SUM_W        = 12;
  localparam int CNT_W        = 4;
  localparam int ROW_W        = 12;
  localparam int CFG_WIDTH_W  = 9;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int MAX_HEIGHT   = 4096;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PX_LOAD,
    ST_PX_R1,
    ST_PX_R2,
    ST_DR_RD,
    ST_DR_LAST,
    ST_DR_PUSH
  } state_t;

  typedef struct packed {
    logic [PIX_W-1:0] older;
    logic [PIX_W-1:0] prev;
  } line_pair_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic             frame_end;
    logic             run_last;
  } job_t;

endpackage

// File: rtl/core/bmf_line_mem.sv
module bmf_line_mem #(
  parameter int DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  bmf_pkg::line_pair_t               wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output bmf_pkg::line_pair_t               rdata
);

  bmf_pkg::line_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/bmf_mean_div.sv
module bmf_mean_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  input  bmf_pkg::job_t              job,
  output logic                       job_ready,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [bmf_pkg::PIX_W-1:0]  m_tdata,
  output logic                       m_tuser,
  output logic                       m_tlast
);

  localparam int PW = 2 * bmf_pkg::SUM_W;
  localparam logic [bmf_pkg::SUM_W-1:0] RECIP3 = 12'd2731;
  localparam logic [bmf_pkg::SUM_W-1:0] RECIP9 = 12'd3641;

  logic [PW-1:0]             p3;
  logic [PW-1:0]             p9;
  logic [bmf_pkg::SUM_W-1:0] quot;

  always_comb begin
    p3 = PW'(job.sum) * PW'(RECIP3);
    p9 = PW'(job.sum) * PW'(RECIP9);
    case (job.cnt)
      4'd2:    quot = job.sum >> 1;
      4'd3:    quot = bmf_pkg::SUM_W'(p3 >> 13);
      4'd4:    quot = job.sum >> 2;
      4'd6:    quot = bmf_pkg::SUM_W'(p3 >> 14);
      4'd9:    quot = bmf_pkg::SUM_W'(p9 >> 15);
      default: quot = job.sum;
    endcase
  end

  assign job_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (job_ready) begin
      m_tvalid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      m_tdata <= quot[bmf_pkg::PIX_W-1:0];
      m_tuser <= job.frame_end;
      m_tlast <= job.run_last;
    end
  end

endmodule

// File: rtl/core/box_mean_filter_3x3.sv
// 3x3 box mean over a raster gray stream, clipped at the frame border and divided by the
// number of cells present (floor). Both rows above the current one sit in one line memory
// of MAX_WIDTH words with a single registered read port; the memory needs no clearing pass
// after reset. A pixel item does its line read in idle as it is taken, then the window update
// and write-back, then one step per window sum it gives (none to two), each waiting for a
// free job register. A drain item reads its up to three columns through the single read port
// one after another, adds in the last read, then pushes its result. Results pass a
// job register and a divide-and-output register, so inputs keep flowing while a result
// waits; the block stalls only when both are full. After the frame's last pixel send one
// drain item per column of the final row; the last carries frame_end.
module box_mean_filter_3x3 #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bmf_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel
  input  logic                            s_tuser,   // [0] req_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bmf_pkg::PIX_W-1:0]       m_tdata,   // [7:0] smoothed
  output logic                            m_tuser,   // [0] frame_end
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (WW > bmf_pkg::CFG_WIDTH_W) ? WW : bmf_pkg::CFG_WIDTH_W;
  localparam int HW = bmf_pkg::CFG_HEIGHT_W;
  localparam int SW = bmf_pkg::SUM_W;
  localparam int NW = bmf_pkg::CNT_W;

  bmf_pkg::state_t state;
  bmf_pkg::state_t state_next;

  logic [bmf_pkg::CFG_WIDTH_W-1:0] width_reg;
  logic [HW-1:0]                   height_reg;
  logic [CW-1:0]                   col_pos;
  logic [bmf_pkg::ROW_W-1:0]       row_pos;
  logic [CW-1:0]                   drain_pos;
  logic                            drain_busy;

  logic [bmf_pkg::PIX_W-1:0] win [3][3];
  logic [bmf_pkg::PIX_W-1:0] px_hold;
  logic has2, top, c_ge1, c_ge2;

  logic [CW-1:0] rd_col;
  logic [CW-1:0] hi_col;
  logic          rd_pend;
  logic [SW-1:0] acc_sum;
  logic [NW-1:0] acc_cnt;
  logic          dr_top;
  logic          dr_fin;

  logic          job_valid;
  bmf_pkg::job_t job;
  bmf_pkg::job_t job_in;
  logic          job_ready;
  logic          job_free;
  logic          job_load;
  logic          px_start;
  logic          dr_start;

  logic [XW-1:0] width_x;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic          col_last;
  logic          row_last;
  logic          dr_fin_c;
  logic [CW-1:0] dr_lo;
  logic [CW-1:0] dr_hi;

  logic                mem_we;
  logic [CW-1:0]       mem_raddr;
  bmf_pkg::line_pair_t mem_wdata;
  bmf_pkg::line_pair_t mem_rdata;

  logic [1:0]    lo_sel;
  logic [1:0]    rs_sel;
  logic [SW-1:0] win_sum;
  logic [NW-1:0] win_cnt;

  always_comb begin
    width_x = XW'(width_reg);
    if (width_x == '0) begin
      eff_w = WW'(1);
    end else if (width_x > XW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_x);
    end
    if (height_reg == '0) begin
      eff_h = HW'(1);
    end else if (height_reg > HW'(bmf_pkg::MAX_HEIGHT)) begin
      eff_h = HW'(bmf_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_reg;
    end
  end

  assign col_last = (WW'(col_pos) + WW'(1)) >= eff_w;
  assign row_last = (HW'(row_pos) + HW'(1)) >= eff_h;
  assign dr_fin_c = (WW'(drain_pos) + WW'(1)) >= eff_w;
  assign dr_lo    = (drain_pos != '0) ? drain_pos - CW'(1) : drain_pos;
  assign dr_hi    = dr_fin_c ? drain_pos : drain_pos + CW'(1);

  always_comb begin
    lo_sel  = (state == bmf_pkg::ST_PX_R2) ? (c_ge1 ? 2'd1 : 2'd2) : (c_ge2 ? 2'd0 : 2'd1);
    rs_sel  = top ? 2'd0 : 2'd1;
    win_sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (2'(i) >= rs_sel && 2'(j) >= lo_sel) begin
          win_sum = win_sum + SW'(win[i][j]);
        end
      end
    end
    win_cnt = (NW'(3) - NW'(rs_sel)) * (NW'(3) - NW'(lo_sel));
  end

  always_comb begin
    if (state == bmf_pkg::ST_DR_PUSH) begin
      job_in.sum       = acc_sum;
      job_in.cnt       = acc_cnt;
      job_in.frame_end = dr_fin;
      job_in.run_last  = 1'b1;
    end else begin
      job_in.sum       = win_sum;
      job_in.cnt       = win_cnt;
      job_in.frame_end = 1'b0;
      job_in.run_last  = (state == bmf_pkg::ST_PX_R2) || !has2;
    end
  end

  assign job_free = !job_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    px_start   = 1'b0;
    dr_start   = 1'b0;
    job_load   = 1'b0;
    unique case (state)
      bmf_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == bmf_pkg::REQ_PIXEL && !drain_busy) begin
            px_start   = 1'b1;
            state_next = bmf_pkg::ST_PX_LOAD;
          end else if (s_tuser == bmf_pkg::REQ_DRAIN && drain_busy) begin
            dr_start   = 1'b1;
            state_next = bmf_pkg::ST_DR_RD;
          end
        end
      end
      bmf_pkg::ST_PX_LOAD: begin
        if (row_pos != '0 && col_pos != '0) begin
          state_next = bmf_pkg::ST_PX_R1;
        end else if (row_pos != '0 && col_last) begin
          state_next = bmf_pkg::ST_PX_R2;
        end else begin
          state_next = bmf_pkg::ST_IDLE;
        end
      end
      bmf_pkg::ST_PX_R1: begin
        if (job_free) begin
          job_load   = 1'b1;
          state_next = has2 ? bmf_pkg::ST_PX_R2 : bmf_pkg::ST_IDLE;
        end
      end
      bmf_pkg::ST_PX_R2: begin
        if (job_free) begin
          job_load   = 1'b1;
          state_next = bmf_pkg::ST_IDLE;
        end
      end
      bmf_pkg::ST_DR_RD: begin
        if (rd_col == hi_col) begin
          state_next = bmf_pkg::ST_DR_LAST;
        end
      end
      bmf_pkg::ST_DR_LAST: begin
        state_next = bmf_pkg::ST_DR_PUSH;
      end
      bmf_pkg::ST_DR_PUSH: begin
        if (job_free) begin
          job_load   = 1'b1;
          state_next = bmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bmf_pkg::ST_IDLE;
      end
    endcase
  end

  // write-back lands before the next read is issued from idle
  assign mem_we          = (state == bmf_pkg::ST_PX_LOAD);
  assign mem_raddr       = (state == bmf_pkg::ST_DR_RD) ? rd_col : col_pos;
  assign mem_wdata.older = mem_rdata.prev;
  assign mem_wdata.prev  = px_hold;

  bmf_line_mem #(
    .DEPTH(MAX_WIDTH)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (col_pos),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= bmf_pkg::CFG_WIDTH_W'(256);
      height_reg <= HW'(256);
      col_pos    <= '0;
      row_pos    <= '0;
      drain_pos  <= '0;
      drain_busy <= 1'b0;
      job_valid  <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == bmf_pkg::CFG_IDX_WIDTH) begin
          width_reg <= cfg_data[bmf_pkg::CFG_WIDTH_W-1:0];
        end else if (cfg_index == bmf_pkg::CFG_IDX_HEIGHT) begin
          height_reg <= cfg_data;
        end
      end
      if (state == bmf_pkg::ST_PX_LOAD) begin
        if (col_last) begin
          col_pos <= '0;
          if (row_last) begin
            drain_busy <= 1'b1;
            drain_pos  <= '0;
          end else begin
            row_pos <= row_pos + bmf_pkg::ROW_W'(1);
          end
        end else begin
          col_pos <= col_pos + CW'(1);
        end
      end
      if (job_load && state == bmf_pkg::ST_DR_PUSH) begin
        if (dr_fin) begin
          drain_busy <= 1'b0;
          drain_pos  <= '0;
          row_pos    <= '0;
          col_pos    <= '0;
        end else begin
          drain_pos <= drain_pos + CW'(1);
        end
      end
      if (dr_start) begin
        rd_pend <= 1'b0;
      end else if (state == bmf_pkg::ST_DR_RD) begin
        rd_pend <= 1'b1;
      end
      if (job_load) begin
        job_valid <= 1'b1;
      end else if (job_ready) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (state == bmf_pkg::ST_PX_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= mem_rdata.older;
      win[1][2] <= mem_rdata.prev;
      win[2][2] <= px_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (px_start) begin
      px_hold <= s_tdata;
    end
    if (state == bmf_pkg::ST_PX_LOAD) begin
      has2  <= (row_pos != '0) && col_last;
      top   <= row_pos >= bmf_pkg::ROW_W'(2);
      c_ge1 <= col_pos != '0;
      c_ge2 <= WW'(col_pos) >= WW'(2);
    end
    if (dr_start) begin
      rd_col  <= dr_lo;
      hi_col  <= dr_hi;
      dr_fin  <= dr_fin_c;
      dr_top  <= row_pos != '0;
      acc_sum <= '0;
      acc_cnt <= '0;
    end else begin
      if (state == bmf_pkg::ST_DR_RD && rd_col != hi_col) begin
        rd_col <= rd_col + CW'(1);
      end
      if ((state == bmf_pkg::ST_DR_RD && rd_pend) || state == bmf_pkg::ST_DR_LAST) begin
        acc_sum <= acc_sum + SW'(mem_rdata.prev) + (dr_top ? SW'(mem_rdata.older) : '0);
        acc_cnt <= acc_cnt + (dr_top ? NW'(2) : NW'(1));
      end
    end
    if (job_load) begin
      job <= job_in;
    end
  end

  bmf_mean_div u_mean_div (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// File: rtl/core/bmf_checker.sv
module bmf_props (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [bmf_pkg::PIX_W-1:0]      s_tdata,
  input logic                           s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bmf_pkg::PIX_W-1:0]      m_tdata,
  input logic                           m_tuser,
  input logic                           m_tlast
);

  a_frame_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame_end result without tlast");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled output transfer changed");

  a_handshake_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({s_tready, m_tvalid}))
    else $error("handshake signal unknown");

endmodule

bind box_mean_filter_3x3 bmf_props u_bmf_props (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// File: bench/bmf_checker.sv
`timescale 1ns / 1ps

module bmf_checker #(
  parameter int LINE_LEN = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [bmf_pkg::PIX_W-1:0]        s_tdata,   // [7:0] pixel
  input  logic                             s_tuser,   // [0] req_type
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [bmf_pkg::PIX_W-1:0]        m_tdata,   // [7:0] smoothed
  input  logic                             m_tuser,   // [0] frame_end
  input  logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               errors,
  output int                               owed
);
  import bmf_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] smoothed;
    logic             frame_end;
    logic             run_last;
  } mean_out_t;

  logic [CFG_WIDTH_W-1:0]  width_reg;
  logic [CFG_HEIGHT_W-1:0] height_reg;
  logic [PIX_W-1:0]        prev_line  [LINE_LEN];
  logic [PIX_W-1:0]        older_line [LINE_LEN];
  logic [PIX_W-1:0]        win        [3][3];
  logic [ROW_W-1:0]        row_at;
  int unsigned             col_at;
  int unsigned             drain_at;
  bit                      draining;
  mean_out_t               means_q [$];
  mean_out_t               slot;
  mean_out_t               head;
  int                      fails = 0;

  function automatic logic [PIX_W-1:0] box_mean(input int unsigned lo, input bit top);
    int unsigned sum;
    int unsigned cnt;
    sum = 0;
    cnt = 0;
    for (int r = top ? 0 : 1; r < 3; r++)
      for (int c = lo; c < 3; c++) begin
        sum += win[r][c];
        cnt++;
      end
    return PIX_W'(sum / cnt);
  endfunction

  task automatic filter_step(input logic kind, input logic [PIX_W-1:0] px);
    int unsigned     w, h, c, r, d, lo, hi, sum, cnt, n;
    logic [PIX_W-1:0] vals [2];
    bit              top, fin;
    w = (width_reg == 0) ? 1 : ((width_reg > LINE_LEN) ? LINE_LEN : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    n = 0;
    if (kind == REQ_PIXEL) begin
      if (!draining) begin
        c = (col_at >= LINE_LEN) ? LINE_LEN - 1 : col_at;
        r = row_at;
        for (int i = 0; i < 3; i++) begin
          win[i][0] = win[i][1];
          win[i][1] = win[i][2];
        end
        win[0][2] = older_line[c];
        win[1][2] = prev_line[c];
        win[2][2] = px;
        older_line[c] = prev_line[c];
        prev_line[c] = px;
        if (r >= 1 && c >= 1) begin
          vals[n] = box_mean(c >= 2 ? 0 : 1, r >= 2);
          n++;
        end
        if (r >= 1 && c + 1 >= w) begin
          vals[n] = box_mean(c >= 1 ? 1 : 2, r >= 2);
          n++;
        end
        for (int i = 0; i < n; i++) begin
          slot.smoothed  = vals[i];
          slot.frame_end = 1'b0;
          slot.run_last  = (i == n - 1);
          means_q.push_back(slot);
        end
        if (c + 1 >= w) begin
          col_at = 0;
          if (r + 1 >= h) begin
            draining = 1'b1;
            drain_at = 0;
          end else begin
            row_at = ROW_W'(r + 1);
          end
        end else begin
          col_at = c + 1;
        end
      end
    end else if (draining) begin
      d   = (drain_at >= LINE_LEN) ? LINE_LEN - 1 : drain_at;
      top = (row_at >= 1);
      lo  = (d >= 1) ? d - 1 : d;
      hi  = (d + 1 < w) ? d + 1 : d;
      sum = 0;
      cnt = 0;
      for (int x = lo; x <= hi; x++) begin
        sum += prev_line[x];
        cnt++;
        if (top) begin
          sum += older_line[x];
          cnt++;
        end
      end
      fin = (d + 1 >= w);
      slot.smoothed  = PIX_W'(sum / cnt);
      slot.frame_end = fin;
      slot.run_last  = 1'b1;
      means_q.push_back(slot);
      if (fin) begin
        draining = 1'b0;
        drain_at = 0;
        row_at   = '0;
        col_at   = 0;
      end else begin
        drain_at = d + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = CFG_WIDTH_W'(256);
      height_reg = CFG_HEIGHT_W'(256);
      for (int i = 0; i < LINE_LEN; i++) begin
        prev_line[i]  = '0;
        older_line[i] = '0;
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          win[i][j] = '0;
      row_at   = '0;
      col_at   = 0;
      drain_at = 0;
      draining = 1'b0;
      means_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_WIDTH)
          width_reg = cfg_data[CFG_WIDTH_W-1:0];
        else
          height_reg = cfg_data[CFG_HEIGHT_W-1:0];
      end
      if (s_tvalid && s_tready)
        filter_step(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        if (means_q.size() == 0) begin
          $error("result with nothing expected: smoothed %0d", m_tdata);
          fails++;
        end else begin
          head = means_q.pop_front();
          if (m_tdata !== head.smoothed) begin
            $error("smoothed: expected %0d, got %0d", head.smoothed, m_tdata);
            fails++;
          end
          if (m_tuser !== head.frame_end) begin
            $error("frame_end: expected %0d, got %0d", head.frame_end, m_tuser);
            fails++;
          end
          if (m_tlast !== head.run_last) begin
            $error("run_last: expected %0d, got %0d", head.run_last, m_tlast);
            fails++;
          end
        end
      end
    end
    errors <= fails;
    owed   <= means_q.size();
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import bmf_pkg::*;

  localparam int LINE_LEN   = 256;
  localparam int HOLD_EVERY = 350;
  localparam int HOLD_LEN   = 300;
  localparam int SETTLE     = 16;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [PIX_W-1:0]      m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    owed;
  int                    xfers = 0;
  int                    items_sent = 0;
  bit                    steady = 1'b0;
  bit                    extremes = 1'b0;

  box_mean_filter_3x3 #(.MAX_WIDTH(LINE_LEN)) dut (.*);

  bmf_checker #(.LINE_LEN(LINE_LEN)) mean_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .owed(owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb failed");
    $finish;
  end

  always @(posedge clk) begin
    if (s_tvalid && s_tready)
      xfers <= xfers + 1;
  end

  initial begin : sink
    int hold_at, left, stall_pct, n;
    m_tready  = 1'b0;
    hold_at   = HOLD_EVERY;
    left      = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (xfers >= hold_at) begin
        hold_at += HOLD_EVERY;
        m_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        if (left == 0) begin
          left = $urandom_range(20, 200);
          case ($urandom_range(2))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            default: stall_pct = 60;
          endcase
        end
        left--;
        if ($urandom_range(99) < stall_pct) begin
          n = ($urandom_range(15) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
          m_tready <= 1'b0;
          repeat (n - 1) @(posedge clk);
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady)
      return 0;
    r = $urandom_range(99);
    if (r < 65)
      return 0;
    if (r < 94)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    int r;
    r = $urandom_range(7);
    if (extremes)
      return r[0] ? '1 : '0;
    if (r == 0)
      return '0;
    if (r == 1)
      return '1;
    return PIX_W'($urandom);
  endfunction

  function automatic int fit(input int v, input int top);
    if (v == 0)
      return 1;
    return (v > top) ? top : v;
  endfunction

  task automatic send(input logic kind, input logic [PIX_W-1:0] px, input bit noise);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    if (!noise)
      items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the input until every expected transfer is out and the pipeline is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sizes(input int w, input int h);
    settle();
    if ($urandom_range(1)) begin
      write_reg(CFG_IDX_WIDTH, w);
      write_reg(CFG_IDX_HEIGHT, h);
    end else begin
      write_reg(CFG_IDX_HEIGHT, h);
      write_reg(CFG_IDX_WIDTH, w);
    end
  endtask

  task automatic send_pixels(input int n);
    repeat (n) begin
      if ($urandom_range(15) == 0)
        send(REQ_DRAIN, PIX_W'($urandom), 1'b1);
      send(REQ_PIXEL, pick_pixel(), 1'b0);
    end
  endtask

  task automatic send_drains(input int n);
    repeat (n) begin
      if ($urandom_range(15) == 0)
        send(REQ_PIXEL, pick_pixel(), 1'b1);
      send(REQ_DRAIN, PIX_W'($urandom), 1'b0);
    end
  endtask

  // with shrink set, stop after k rows and j pixels, then resize the frame and finish it
  task automatic run_frame(input int w0, input int h0, input bit shrink,
                           input int k, input int j, input int w1, input int h1);
    int we0, he0, we1, he1, row_rest, rows_after;
    set_sizes(w0, h0);
    we0 = fit(w0, LINE_LEN);
    he0 = fit(h0, MAX_HEIGHT);
    if (!shrink) begin
      send_pixels(we0 * he0);
      send_drains(we0);
    end else begin
      send_pixels(k * we0 + j);
      set_sizes(w1, h1);
      we1        = fit(w1, LINE_LEN);
      he1        = fit(h1, MAX_HEIGHT);
      row_rest   = (we1 > j) ? we1 - j : 1;
      rows_after = (k + 1 >= he1) ? 0 : he1 - k - 1;
      send_pixels(row_rest + rows_after * we1);
      send_drains(we1);
    end
    if ($urandom_range(7) == 0)
      send(REQ_DRAIN, PIX_W'($urandom), 1'b1);
  endtask

  initial begin : stim
    int w0, h0, w1, h1, k, j;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = REQ_PIXEL;
    cfg_we    = 1'b0;
    cfg_index = CFG_IDX_WIDTH;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    extremes = 1'b1;
    send(REQ_DRAIN, 8'h5A, 1'b1);
    repeat (3) send(REQ_PIXEL, pick_pixel(), 1'b0);
    set_sizes(0, 0);
    send(REQ_PIXEL, 8'h80, 1'b0);
    send(REQ_PIXEL, 8'h7F, 1'b1);
    send(REQ_DRAIN, 8'h00, 1'b0);
    send(REQ_DRAIN, 8'hFF, 1'b1);
    run_frame(3, 3, 1'b0, 0, 0, 0, 0);
    extremes = 1'b0;

    run_frame(LINE_LEN, 8191, 1'b1, 1, 0, 511, 0);

    while (items_sent < 1000) begin
      steady = ($urandom_range(3) == 0);
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(9) == 0)
          w0 = 0;
        else if ($urandom_range(9) == 0)
          w0 = $urandom_range(13, 40);
        else
          w0 = $urandom_range(1, 12);
        h0 = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 7);
        run_frame(w0, h0, 1'b0, 0, 0, 0, 0);
      end else begin
        w0 = $urandom_range(2, 12);
        h0 = ($urandom_range(7) == 0) ? 8191 : $urandom_range(2, 6);
        k  = $urandom_range(0, ((h0 > 6) ? 6 : h0) - 1);
        j  = $urandom_range(0, w0 - 1);
        w1 = $urandom_range(0, w0);
        h1 = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 8);
        run_frame(w0, h0, 1'b1, k, j, w1, h1);
      end
    end
    steady = 1'b0;

    settle();
    if (errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
